[hw/rtl/mp4_protection_box_scanner_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the protection box scanner checker.
// All macros sample on clk; the first two are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MP4_PROTECTION_BOX_SCANNER_ASSERT_SVH
`define MP4_PROTECTION_BOX_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MP4PBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define MP4PBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that is checked during reset as well.
`define MP4PBS_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[hw/rtl/mp4pbs_pkg.sv]
// ---------------------------------------------------------------------------
// mp4pbs_pkg
// Types and constants shared by the protection box scanner modules.
// ---------------------------------------------------------------------------
package mp4pbs_pkg;

  localparam int WinLen = 32;
  localparam int SysIdBytes = 16;
  localparam int SysIdAt = 12;
  localparam int KeyIdAt = 16;

  localparam logic [31:0] MinBoxSize = 32'd32;
  localparam logic [31:0] PsshType = 32'h7073_7368;
  localparam logic [31:0] TencType = 32'h7465_6e63;

  localparam logic [127:0] SysIdOne = 128'hedef8ba979d64acea3c827dcd51d21ed;
  localparam logic [127:0] SysIdTwo = 128'h9a04f07998404286ab92e65be0885f95;

  localparam logic KindPssh = 1'b0;
  localparam logic KindTenc = 1'b1;

  localparam logic [1:0] ClassOther = 2'd0;
  localparam logic [1:0] ClassSysOne = 2'd1;
  localparam logic [1:0] ClassSysTwo = 2'd2;

  typedef logic [WinLen-1:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    logic        match_kind;
    logic [31:0] box_offset;
    logic [31:0] box_size;
    logic [1:0]  system_class;
    logic [63:0] key_id_high;
    logic [63:0] key_id_low;
  } out_t;

endpackage

[hw/rtl/mp4_protection_box_scanner.sv]
// ---------------------------------------------------------------------------
// mp4_protection_box_scanner
// Scans an init segment byte stream for pssh and tenc box headers.
// ---------------------------------------------------------------------------
//  Channel | Ports                         | Moves
//  --------+-------------------------------+------------------------------
//  input   | in_valid, in_stall, in_data   | one segment byte per transaction
//  result  | out_valid, out_stall, out_data| one found box per transaction
//  config  | cfg_wr_en, cfg_wr_data        | segment length write
//
// One byte is accepted every cycle while in_stall is low; a result is
// registered from the byte that completes its 32-byte window. The window
// shift and one header compare per byte set this rate. A two-entry output
// register and skid stage let bytes keep flowing while one result waits;
// in_stall rises only when both entries are full. Reset clears the offset,
// the segment length and the output valids.
// ---------------------------------------------------------------------------
module mp4_protection_box_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mp4pbs_pkg::in_t     in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mp4pbs_pkg::out_t    out_data,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);

  logic [31:0]      seg_len_r;
  logic [31:0]      pos_r, pos_nxt;
  mp4pbs_pkg::win_t win_r, win_nxt;
  mp4pbs_pkg::out_t out_r, out_nxt;
  mp4pbs_pkg::out_t skid_r, skid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [31:0]      off;
  logic             accept;
  logic             take;
  logic             hit;
  mp4pbs_pkg::out_t res;

  assign accept = in_valid && !skid_valid_r;
  assign take = out_valid_r && !out_stall;
  assign off = in_data.first_byte ? 32'd0 : pos_r;
  assign pos_nxt = (off == '1) ? off : off + 32'd1;
  assign win_nxt = {in_data.data_byte, win_r[mp4pbs_pkg::WinLen-1:1]};

  mp4pbs_judge u_judge (
    .win     (win_nxt),
    .off     (off),
    .seg_len (seg_len_r),
    .hit     (hit),
    .res     (res)
  );

  always_comb begin
    out_nxt = out_r;
    skid_nxt = skid_r;
    out_valid_nxt = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (take) begin
      if (skid_valid_r) begin
        out_nxt = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (accept && hit) begin
      if (!out_valid_nxt) begin
        out_nxt = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt = res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r <= '0;
      pos_r <= '0;
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seg_len_r <= cfg_wr_data;
      end
      if (accept) begin
        pos_r <= pos_nxt;
      end
      out_valid_r <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
    out_r <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

[hw/rtl/mp4pbs_judge.sv]
// ---------------------------------------------------------------------------
// mp4pbs_judge
// Judges the candidate box header at the oldest byte of the window.
// ---------------------------------------------------------------------------
module mp4pbs_judge (
  input  mp4pbs_pkg::win_t win,
  input  logic [31:0]      off,
  input  logic [31:0]      seg_len,
  output logic             hit,
  output mp4pbs_pkg::out_t res
);

  logic [31:0]  start;
  logic [31:0]  size;
  logic [31:0]  box_type;
  logic [127:0] sys_id;
  logic [127:0] key_id;
  logic [32:0]  box_end;
  logic         full;
  logic         fits;
  logic         is_pssh;
  logic         is_tenc;

  assign sys_id = {<<8{win[mp4pbs_pkg::SysIdAt + mp4pbs_pkg::SysIdBytes - 1 :
                           mp4pbs_pkg::SysIdAt]}};
  assign key_id = {<<8{win[mp4pbs_pkg::KeyIdAt + mp4pbs_pkg::SysIdBytes - 1 :
                           mp4pbs_pkg::KeyIdAt]}};

  assign size = {win[0], win[1], win[2], win[3]};
  assign box_type = {win[4], win[5], win[6], win[7]};
  assign full = off >= 32'(mp4pbs_pkg::WinLen - 1);
  assign start = off - 32'(mp4pbs_pkg::WinLen - 1);
  assign box_end = {1'b0, start} + {1'b0, size};
  assign fits = (size >= mp4pbs_pkg::MinBoxSize) && (box_end <= {1'b0, seg_len});
  assign is_pssh = box_type == mp4pbs_pkg::PsshType;
  assign is_tenc = box_type == mp4pbs_pkg::TencType;
  assign hit = full && fits && (is_pssh || is_tenc);

  always_comb begin
    res.box_offset = start;
    res.box_size = size;
    if (is_pssh) begin
      res.match_kind = mp4pbs_pkg::KindPssh;
      res.key_id_high = '0;
      res.key_id_low = '0;
      if (sys_id == mp4pbs_pkg::SysIdOne) begin
        res.system_class = mp4pbs_pkg::ClassSysOne;
      end else if (sys_id == mp4pbs_pkg::SysIdTwo) begin
        res.system_class = mp4pbs_pkg::ClassSysTwo;
      end else begin
        res.system_class = mp4pbs_pkg::ClassOther;
      end
    end else begin
      res.match_kind = mp4pbs_pkg::KindTenc;
      res.system_class = mp4pbs_pkg::ClassOther;
      res.key_id_high = key_id[127:64];
      res.key_id_low = key_id[63:0];
    end
  end

endmodule

[hw/rtl/mp4pbs_checker.sv]
// ---------------------------------------------------------------------------
// mp4pbs_checker
// Port-level checks on the protection box scanner, bound to the top level.
// ---------------------------------------------------------------------------
`include "mp4_protection_box_scanner_assert.svh"

module mp4pbs_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input mp4pbs_pkg::in_t  in_data,
  input logic             out_valid,
  input logic             out_stall,
  input mp4pbs_pkg::out_t out_data,
  input logic             cfg_wr_en,
  input logic [31:0]      cfg_wr_data
);

  logic is_pssh;
  logic is_tenc;
  logic unused_ok;

  assign is_pssh = out_data.match_kind == mp4pbs_pkg::KindPssh;
  assign is_tenc = out_data.match_kind == mp4pbs_pkg::KindTenc;
  assign unused_ok = in_valid ^ in_stall ^ (^in_data) ^ cfg_wr_en ^ (^cfg_wr_data);

  `MP4PBS_ASSERT_NXT_RST(a_reset_clears_out, !rst_n, !out_valid)
  `MP4PBS_ASSERT_NXT(a_stalled_out_holds, out_valid && out_stall,
                     out_valid && $stable(out_data))
  `MP4PBS_ASSERT_IMP(a_size_min, out_valid, out_data.box_size >= mp4pbs_pkg::MinBoxSize)
  `MP4PBS_ASSERT_IMP(a_pssh_no_key, out_valid && is_pssh,
                     out_data.key_id_high == '0 && out_data.key_id_low == '0)
  `MP4PBS_ASSERT_IMP(a_tenc_no_class, out_valid && is_tenc,
                     out_data.system_class == mp4pbs_pkg::ClassOther)

endmodule

bind mp4_protection_box_scanner mp4pbs_checker u_mp4pbs_checker (.*);
